[rtl/core/idll_pkg.sv]
// ----------------------------------------------------------------------------
// idll_pkg
// Shared types and codes for the indexed doubly linked list block.
// ----------------------------------------------------------------------------
package idll_pkg;

  // Id space is fixed by the field width
  localparam int ID_W     = 10;
  localparam int ID_SPACE = 1 << ID_W;
  localparam int CMD_W    = 3;
  localparam int STAT_W   = 2;

  typedef logic [ID_W-1:0]   id_t;
  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [STAT_W-1:0] status_t;

  // Command codes
  localparam cmd_t CMD_INS_PREV = 3'd0;
  localparam cmd_t CMD_INS_NEXT = 3'd1;
  localparam cmd_t CMD_DELETE   = 3'd2;
  localparam cmd_t CMD_ASK_PREV = 3'd3;
  localparam cmd_t CMD_ASK_NEXT = 3'd4;
  localparam cmd_t CMD_HEAD     = 3'd5;

  // Status codes
  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_ABSENT = 2'd1;
  localparam status_t ST_FULL   = 2'd2;
  localparam status_t ST_DUP    = 2'd3;

  // Decoded command class; all zero for an unknown code
  typedef struct packed {
    logic ins;
    logic del;
    logic ask;
    logic head;
    logic prev_side;
  } op_class_t;

  typedef struct packed {
    op_class_t cls;
    id_t       anchor_id;
    id_t       new_id;
  } item_t;

  // Head of the command queue as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

endpackage

[rtl/core/idll_cmd_if.sv]
// ----------------------------------------------------------------------------
// idll_cmd_if
// Command channel: valid/ready handshake with the command word payload.
// ----------------------------------------------------------------------------
interface idll_cmd_if;
  logic           valid;
  logic           ready;
  idll_pkg::cmd_t command;
  idll_pkg::id_t  anchor_id;
  idll_pkg::id_t  new_id;

  modport source (output valid, output command, output anchor_id, output new_id,
                  input ready);
  modport sink   (input valid, input command, input anchor_id, input new_id,
                  output ready);
endinterface

[rtl/core/idll_rsp_if.sv]
// ----------------------------------------------------------------------------
// idll_rsp_if
// Response channel: valid/ready handshake with the result word payload.
// ----------------------------------------------------------------------------
interface idll_rsp_if;
  logic              valid;
  logic              ready;
  idll_pkg::id_t     value;
  idll_pkg::status_t status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

[rtl/core/idll_ram.sv]
// ----------------------------------------------------------------------------
// idll_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module idll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/idll_front.sv]
// ----------------------------------------------------------------------------
// idll_front
// Accepts command words, decodes them into an operation class and queues
// them for the back end.
// ----------------------------------------------------------------------------
module idll_front (
  input  logic               clk,
  input  logic               rst,
  idll_cmd_if.sink           cmd,
  input  logic               init_done,
  input  logic               pop,
  output idll_pkg::q_head_t  head
);

  localparam int QDEPTH = 2;
  localparam int PW     = $clog2(QDEPTH);

  idll_pkg::item_t   q_mem [QDEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [PW:0]       count;
  idll_pkg::op_class_t cls;
  logic              push;

  // Command decode
  always_comb begin
    cls = '0;
    unique case (cmd.command)
      idll_pkg::CMD_INS_PREV: begin
        cls.ins       = 1'b1;
        cls.prev_side = 1'b1;
      end
      idll_pkg::CMD_INS_NEXT: cls.ins = 1'b1;
      idll_pkg::CMD_DELETE:   cls.del = 1'b1;
      idll_pkg::CMD_ASK_PREV: begin
        cls.ask       = 1'b1;
        cls.prev_side = 1'b1;
      end
      idll_pkg::CMD_ASK_NEXT: cls.ask  = 1'b1;
      idll_pkg::CMD_HEAD:     cls.head = 1'b1;
      default:                cls = '0;
    endcase
  end

  // No words taken until the tables are initialized
  assign cmd.ready = init_done && (count != (PW+1)'(QDEPTH));
  assign push      = cmd.valid && cmd.ready;

  assign head.valid = (count != '0);
  assign head.item  = q_mem[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= '{cls: cls, anchor_id: cmd.anchor_id, new_id: cmd.new_id};
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue popped while empty");

endmodule

[rtl/core/idll_back.sv]
// ----------------------------------------------------------------------------
// idll_back
// Executes queued commands against the slot tables: a short sequence of
// dependent table reads, then link updates, then the result word.
// ----------------------------------------------------------------------------
module idll_back #(
  parameter int NODES = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  idll_pkg::q_head_t head,
  output logic              pop,
  output logic              init_done,
  idll_rsp_if.source        rsp
);

  localparam int SW = $clog2(NODES);
  localparam logic [SW-1:0] FULL_MARK = SW'(NODES - 1);
  localparam logic [SW-1:0] SLOT_ONE  = SW'(1);

  // Sequencer states
  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RDY  = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_W2   = 3'd4;
  localparam logic [2:0] S_RDV  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]        state;
  idll_pkg::id_t     sweep;
  idll_pkg::item_t   cur;
  logic              pres_a;
  logic [SW-1:0]     s_r;
  logic [SW-1:0]     p_r;
  logic [SW-1:0]     q_r;
  logic [SW-1:0]     n_r;
  logic              zero_r;
  logic [SW-1:0]     next_free;
  logic [SW-1:0]     head_slot;
  idll_pkg::id_t     res_value;
  idll_pkg::status_t res_status;
  logic              rsp_valid;
  idll_pkg::id_t     rsp_value;
  idll_pkg::status_t rsp_status;

  // RAM ports
  logic              pres_we, pres_wd, pres_rd;
  idll_pkg::id_t     pres_wa, pres_ra;
  logic              idslot_we;
  idll_pkg::id_t     idslot_wa, idslot_ra;
  logic [SW-1:0]     idslot_wd, idslot_rd;
  logic              slotid_we;
  logic [SW-1:0]     slotid_wa, slotid_ra;
  idll_pkg::id_t     slotid_wd, slotid_rd;
  logic              prev_we, next_we;
  logic [SW-1:0]     prev_wa, prev_ra, prev_wd, prev_rd;
  logic [SW-1:0]     next_wa, next_ra, next_wd, next_rd;

  // Evaluation terms
  logic              anchor_bad, full, dup, ins_ok, del_ok;
  logic [SW-1:0]     n_slot;
  idll_pkg::status_t eval_status;
  idll_pkg::id_t     eval_value;
  logic              out_free;

  idll_ram #(.WIDTH(1), .DEPTH(idll_pkg::ID_SPACE)) u_present (
    .clk(clk), .we(pres_we), .waddr(pres_wa), .wdata(pres_wd),
    .raddr(pres_ra), .rdata(pres_rd));

  idll_ram #(.WIDTH(SW), .DEPTH(idll_pkg::ID_SPACE)) u_id_slot (
    .clk(clk), .we(idslot_we), .waddr(idslot_wa), .wdata(idslot_wd),
    .raddr(idslot_ra), .rdata(idslot_rd));

  idll_ram #(.WIDTH(idll_pkg::ID_W), .DEPTH(NODES)) u_slot_id (
    .clk(clk), .we(slotid_we), .waddr(slotid_wa), .wdata(slotid_wd),
    .raddr(slotid_ra), .rdata(slotid_rd));

  idll_ram #(.WIDTH(SW), .DEPTH(NODES)) u_prev_link (
    .clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
    .raddr(prev_ra), .rdata(prev_rd));

  idll_ram #(.WIDTH(SW), .DEPTH(NODES)) u_next_link (
    .clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
    .raddr(next_ra), .rdata(next_rd));

  assign init_done = (state != S_INIT);
  assign out_free  = !rsp_valid || rsp.ready;
  assign pop = head.valid && ((state == S_IDLE) || (state == S_DONE && out_free));

  assign rsp.valid  = rsp_valid;
  assign rsp.value  = rsp_value;
  assign rsp.status = rsp_status;

  // Command checks, valid in S_EVAL
  always_comb begin
    anchor_bad = (cur.cls.ins || cur.cls.del || cur.cls.ask) && !pres_a;
    full       = (next_free >= FULL_MARK);
    dup        = (cur.new_id == '0) || pres_rd;
    ins_ok     = cur.cls.ins && !anchor_bad && !full && !dup;
    del_ok     = cur.cls.del && !anchor_bad;
    n_slot     = next_free + 1'b1;
    if (anchor_bad) begin
      eval_status = idll_pkg::ST_ABSENT;
    end else if (cur.cls.ins && full) begin
      eval_status = idll_pkg::ST_FULL;
    end else if (cur.cls.ins && dup) begin
      eval_status = idll_pkg::ST_DUP;
    end else begin
      eval_status = idll_pkg::ST_OK;
    end
    eval_value = (cur.cls.head && head_slot != '0) ? slotid_rd : '0;
  end

  // RAM addressing and writes
  always_comb begin
    pres_ra   = head.item.anchor_id;
    idslot_ra = head.item.anchor_id;
    prev_ra   = idslot_rd;
    next_ra   = idslot_rd;
    slotid_ra = head_slot;
    pres_we   = 1'b0;
    pres_wa   = sweep;
    pres_wd   = 1'b0;
    idslot_we = 1'b0;
    idslot_wa = sweep;
    idslot_wd = '0;
    slotid_we = 1'b0;
    slotid_wa = SLOT_ONE;
    slotid_wd = idll_pkg::id_t'(1);
    prev_we   = 1'b0;
    prev_wa   = SLOT_ONE;
    prev_wd   = '0;
    next_we   = 1'b0;
    next_wa   = SLOT_ONE;
    next_wd   = '0;
    unique case (state)
      S_INIT: begin
        // id 1 in slot 1, every other id absent
        pres_we   = 1'b1;
        pres_wd   = (sweep == idll_pkg::id_t'(1));
        idslot_we = 1'b1;
        idslot_wd = (sweep == idll_pkg::id_t'(1)) ? SLOT_ONE : '0;
        slotid_we = (sweep == idll_pkg::id_t'(1));
        prev_we   = (sweep == idll_pkg::id_t'(1));
        next_we   = (sweep == idll_pkg::id_t'(1));
      end
      S_RDY: begin
        pres_ra = cur.new_id;
      end
      S_EVAL: begin
        slotid_ra = cur.cls.prev_side ? prev_rd : next_rd;
        if (ins_ok) begin
          pres_we   = 1'b1;
          pres_wa   = cur.new_id;
          pres_wd   = 1'b1;
          idslot_we = 1'b1;
          idslot_wa = cur.new_id;
          idslot_wd = n_slot;
          slotid_we = 1'b1;
          slotid_wa = n_slot;
          slotid_wd = cur.new_id;
          prev_we   = 1'b1;
          prev_wa   = n_slot;
          prev_wd   = cur.cls.prev_side ? prev_rd : s_r;
          next_we   = 1'b1;
          next_wa   = n_slot;
          next_wd   = cur.cls.prev_side ? s_r : next_rd;
        end else if (del_ok) begin
          pres_we = 1'b1;
          pres_wa = cur.anchor_id;
          pres_wd = 1'b0;
          next_we = (prev_rd != '0);
          next_wa = prev_rd;
          next_wd = next_rd;
          prev_we = (next_rd != '0);
          prev_wa = next_rd;
          prev_wd = prev_rd;
        end
      end
      S_W2: begin
        // Splice the new slot into its neighbors
        if (cur.cls.prev_side) begin
          next_we = (p_r != '0);
          next_wa = p_r;
          next_wd = n_r;
          prev_we = 1'b1;
          prev_wa = s_r;
          prev_wd = n_r;
        end else begin
          prev_we = (q_r != '0);
          prev_wa = q_r;
          prev_wd = n_r;
          next_we = 1'b1;
          next_wa = s_r;
          next_wd = n_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      sweep     <= '0;
      next_free <= SLOT_ONE;
      head_slot <= SLOT_ONE;
      rsp_valid <= 1'b0;
    end else begin
      if (pop) begin
        cur <= head.item;
      end
      unique case (state)
        S_INIT: begin
          sweep <= sweep + 1'b1;
          if (sweep == idll_pkg::id_t'(idll_pkg::ID_SPACE - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (head.valid) begin
            state <= S_RDY;
          end
        end
        S_RDY: begin
          pres_a <= pres_rd;
          s_r    <= idslot_rd;
          state  <= S_EVAL;
        end
        S_EVAL: begin
          p_r        <= prev_rd;
          q_r        <= next_rd;
          n_r        <= n_slot;
          zero_r     <= ((cur.cls.prev_side ? prev_rd : next_rd) == '0);
          res_status <= eval_status;
          res_value  <= eval_value;
          if (ins_ok) begin
            next_free <= n_slot;
            if (cur.cls.prev_side && s_r == head_slot) begin
              head_slot <= n_slot;
            end
            state <= S_W2;
          end else if (del_ok) begin
            if (s_r == head_slot) begin
              head_slot <= next_rd;
            end
            state <= S_DONE;
          end else if (cur.cls.ask && !anchor_bad) begin
            state <= S_RDV;
          end else begin
            state <= S_DONE;
          end
        end
        S_W2: begin
          state <= S_DONE;
        end
        S_RDV: begin
          res_value <= zero_r ? '0 : slotid_rd;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= head.valid ? S_RDY : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // Output register
      if (state == S_DONE && out_free) begin
        rsp_valid  <= 1'b1;
        rsp_value  <= res_value;
        rsp_status <= res_status;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_init_no_pop: assert property (@(posedge clk) disable iff (rst)
    state == S_INIT |-> !pop)
    else $error("command taken during table init");

  a_pop_starts: assert property (@(posedge clk) disable iff (rst)
    pop |=> state == S_RDY)
    else $error("popped command not started");

  a_w2_after_ins: assert property (@(posedge clk) disable iff (rst)
    state == S_W2 |-> $past(state) == S_EVAL && cur.cls.ins)
    else $error("link splice without an insert");

  a_value_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_value != '0 |-> rsp_status == idll_pkg::ST_OK)
    else $error("nonzero value with error status");

endmodule

[rtl/core/indexed_doubly_linked_list.sv]
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list
// Ordered list of node ids held in slot tables with prev/next links, an
// id-to-slot map and a head pointer. Insert, delete and neighbor queries.
//
//   channel | dir | payload                          | handshake
//   --------+-----+----------------------------------+------------
//   cmd     | in  | command, anchor_id, new_id       | valid/ready
//   rsp     | out | value, status                    | valid/ready
//
// Delete, head read, unknown codes and error cases run the states RDY,
// EVAL and DONE; insert adds the second link write state W2 and neighbor
// queries the neighbor id read state RDV, set by the chain of registered
// table reads: id to slot, slot to links, links to neighbor id.
// After reset an init pass over the whole id space clears the id tables;
// cmd.ready stays low until it ends. A two-word queue lets cmd be taken
// while rsp is stalled; a held rsp word stalls the back end only.
// ----------------------------------------------------------------------------
module indexed_doubly_linked_list #(
  parameter int NODES = 1024
) (
  input logic         clk,
  input logic         rst,
  idll_cmd_if.sink    cmd,
  idll_rsp_if.source  rsp
);

  idll_pkg::q_head_t q_head;
  logic              pop;
  logic              init_done;

  idll_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .init_done (init_done),
    .pop       (pop),
    .head      (q_head)
  );

  idll_back #(.NODES(NODES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .pop       (pop),
    .init_done (init_done),
    .rsp       (rsp)
  );

endmodule
